>>> src/fblcd_pkg.sv
// ----------------------------------------------------------------------------
// fblcd_pkg
// Shared constants and types for the framebuffer to LCD page stream unit.
// ----------------------------------------------------------------------------
package fblcd_pkg;

  localparam int unsigned DefWidth  = 128;
  localparam int unsigned DefHeight = 64;

  localparam int unsigned AddrW = 10;
  localparam int unsigned PixW  = 8;

  // LCD controller commands
  localparam logic [PixW-1:0] CmdColHi = 8'h10;
  localparam logic [PixW-1:0] CmdColLo = 8'h00;
  localparam logic [PixW-1:0] CmdPage  = 8'hB0;
  localparam logic [PixW-1:0] PageMask = 8'h0F;

  typedef enum logic [1:0] {
    SeqIdle,
    SeqRead,
    SeqData
  } seq_state_e;

  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [PixW-1:0]  wr_data;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } store_req_t;

endpackage

>>> src/framebuffer_to_lcd_page_stream_unit.sv
// ----------------------------------------------------------------------------
// framebuffer_to_lcd_page_stream_unit
// 1-bit framebuffer streamed to a page-organised LCD as 8x8 transposed tiles.
// ----------------------------------------------------------------------------
// Input: an item is taken on a clock edge with start high and busy low.
//   op_i = 0 writes pixels_i to framebuffer byte addr_i and marks the
//   picture dirty (addresses beyond the picture are dropped).
//   op_i = 1 advances the flush by one tile; idle and clean it does nothing.
// Output: every beat sits on lcd_byte_o/is_data_o/last_o/frame_done_o for one
//   cycle with out_valid_o high; the receiver cannot stall it.
// Advance: the three addressing commands (tile column 0 only) go out while
//   the tile rows are read, and the eight data beats follow them. The single
//   read port of the framebuffer fetches the eight tile rows one per cycle
//   before the data beats go out; busy stays high through the last data beat.
// Reset: all control state clears and a clearing pass zeroes all BPR*HEIGHT
//   framebuffer bytes (1024 by default), one byte per cycle; busy stays high
//   throughout.
// ----------------------------------------------------------------------------
module framebuffer_to_lcd_page_stream_unit #(
  parameter int unsigned WIDTH  = fblcd_pkg::DefWidth,
  parameter int unsigned HEIGHT = fblcd_pkg::DefHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [fblcd_pkg::AddrW-1:0]   addr_i,
  input  logic [fblcd_pkg::PixW-1:0]    pixels_i,
  output logic                          out_valid_o,
  output logic [fblcd_pkg::PixW-1:0]    lcd_byte_o,
  output logic                          is_data_o,
  output logic                          last_o,
  output logic                          frame_done_o
);

  localparam int unsigned DEPTH = ((WIDTH + 7) / 8) * HEIGHT;

  fblcd_pkg::store_req_t      store_req;
  logic [fblcd_pkg::PixW-1:0] rd_data;
  logic                       clear_busy;

  fblcd_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (store_req),
    .rd_data_o    (rd_data),
    .clear_busy_o (clear_busy)
  );

  fblcd_seq #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .op_i         (op_i),
    .addr_i       (addr_i),
    .pixels_i     (pixels_i),
    .clear_busy_i (clear_busy),
    .rd_data_i    (rd_data),
    .store_req_o  (store_req),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .lcd_byte_o   (lcd_byte_o),
    .is_data_o    (is_data_o),
    .last_o       (last_o),
    .frame_done_o (frame_done_o)
  );

endmodule

>>> src/fblcd_store.sv
// ----------------------------------------------------------------------------
// fblcd_store
// Framebuffer memory: one write port, one registered read port, and a
// clearing pass after reset that zeroes every entry, one per cycle.
// ----------------------------------------------------------------------------
module fblcd_store #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fblcd_pkg::store_req_t        req_i,
  output logic [fblcd_pkg::PixW-1:0]   rd_data_o,
  output logic                         clear_busy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] ClrLast = AW'(DEPTH - 1);

  logic [fblcd_pkg::PixW-1:0] mem [DEPTH];
  logic [fblcd_pkg::PixW-1:0] rd_data_q;
  logic [AW-1:0]              clr_cnt_q, clr_cnt_d;
  logic                       clearing_q, clearing_d;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [fblcd_pkg::PixW-1:0] wdata;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == ClrLast) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clearing_q <= clearing_d;
    end
  end

  assign we    = clearing_q | req_i.wr_en;
  assign waddr = clearing_q ? clr_cnt_q : req_i.wr_addr[AW-1:0];
  assign wdata = clearing_q ? '0 : req_i.wr_data;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o    = rd_data_q;
  assign clear_busy_o = clearing_q;

  a_no_wr_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !req_i.wr_en && !req_i.rd_en)
    else $error("store accessed during clearing pass");

  a_rd_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.rd_en |-> (32'(req_i.rd_addr) < DEPTH))
    else $error("read beyond framebuffer");

  a_wr_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.wr_en |-> (32'(req_i.wr_addr) < DEPTH))
    else $error("write beyond framebuffer");

  a_clear_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> $past(clr_cnt_q) == ClrLast)
    else $error("clearing pass ended early");

endmodule

>>> src/fblcd_seq.sv
// ----------------------------------------------------------------------------
// fblcd_seq
// Command decode and tile sequencer: stores pixel bytes, reads the eight rows
// of a tile, emits the page addressing commands and the transposed bytes.
// ----------------------------------------------------------------------------
module fblcd_seq #(
  parameter int unsigned WIDTH  = fblcd_pkg::DefWidth,
  parameter int unsigned HEIGHT = fblcd_pkg::DefHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          op_i,
  input  logic [fblcd_pkg::AddrW-1:0]   addr_i,
  input  logic [fblcd_pkg::PixW-1:0]    pixels_i,
  input  logic                          clear_busy_i,
  input  logic [fblcd_pkg::PixW-1:0]    rd_data_i,
  output fblcd_pkg::store_req_t         store_req_o,
  output logic                          busy_o,
  output logic                          out_valid_o,
  output logic [fblcd_pkg::PixW-1:0]    lcd_byte_o,
  output logic                          is_data_o,
  output logic                          last_o,
  output logic                          frame_done_o
);

  localparam int unsigned BPR    = (WIDTH + 7) / 8;
  localparam int unsigned PAGES  = (HEIGHT + 7) / 8;
  localparam int unsigned DEPTH  = BPR * HEIGHT;
  localparam int unsigned TILE_W = (BPR > 1) ? $clog2(BPR) : 1;
  localparam int unsigned PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned ROW_W  = PAGE_W + 3;
  localparam int unsigned CALC_W = fblcd_pkg::AddrW + 1;
  localparam logic [TILE_W-1:0] TileLast = TILE_W'(BPR - 1);
  localparam logic [PAGE_W-1:0] PageLast = PAGE_W'(PAGES - 1);

  fblcd_pkg::seq_state_e state_q, state_d;
  logic [3:0]                 cnt_q, cnt_d;
  logic [PAGE_W-1:0]          page_q, page_d;
  logic [TILE_W-1:0]          tile_q, tile_d;
  logic                       dirty_q, dirty_d;
  logic                       active_q, active_d;
  logic                       zero_q, zero_d;
  logic [fblcd_pkg::PixW-1:0] rows_q [8];
  logic [fblcd_pkg::PixW-1:0] rows_d [8];

  logic              accept;
  logic [ROW_W-1:0]  row;
  logic              row_ok;
  logic [CALC_W-1:0] row_addr;
  logic              addr_ok;
  logic              final_tile;

  assign busy_o     = (state_q != fblcd_pkg::SeqIdle) || clear_busy_i;
  assign accept     = start_i && !busy_o;
  assign row        = {page_q, cnt_q[2:0]};
  assign row_ok     = (32'(row) < HEIGHT);
  assign row_addr   = CALC_W'(row) * CALC_W'(BPR) + CALC_W'(tile_q);
  assign addr_ok    = (CALC_W'(addr_i) < CALC_W'(DEPTH));
  assign final_tile = (tile_q == TileLast) && (page_q == PageLast);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    page_d      = page_q;
    tile_d      = tile_q;
    dirty_d     = dirty_q;
    active_d    = active_q;
    zero_d      = zero_q;
    rows_d      = rows_q;
    store_req_o = '0;
    out_valid_o = 1'b0;
    lcd_byte_o  = '0;
    is_data_o   = 1'b0;
    last_o      = 1'b0;
    frame_done_o = 1'b0;

    unique case (state_q)
      fblcd_pkg::SeqIdle: begin
        if (accept) begin
          if (!op_i) begin
            if (addr_ok) begin
              store_req_o.wr_en   = 1'b1;
              store_req_o.wr_addr = addr_i;
              store_req_o.wr_data = pixels_i;
              dirty_d             = 1'b1;
            end
          end else if (active_q || dirty_q) begin
            if (!active_q) begin
              active_d = 1'b1;
              dirty_d  = 1'b0;
              page_d   = '0;
              tile_d   = '0;
            end
            cnt_d   = '0;
            state_d = fblcd_pkg::SeqRead;
          end
        end
      end
      fblcd_pkg::SeqRead: begin
        if (!cnt_q[3]) begin
          store_req_o.rd_en   = row_ok;
          store_req_o.rd_addr = row_addr[fblcd_pkg::AddrW-1:0];
          zero_d              = !row_ok;
        end
        // beat from the read issued in the previous cycle
        if (cnt_q != 4'd0) begin
          for (int i = 0; i < 7; i++) begin
            rows_d[i] = rows_q[i+1];
          end
          rows_d[7] = rd_data_i & {fblcd_pkg::PixW{!zero_q}};
        end
        if (tile_q == '0 && cnt_q < 4'd3) begin
          out_valid_o = 1'b1;
          priority if (cnt_q == 4'd0) begin
            lcd_byte_o = fblcd_pkg::CmdColHi;
          end else if (cnt_q == 4'd1) begin
            lcd_byte_o = fblcd_pkg::CmdColLo;
          end else begin
            lcd_byte_o = fblcd_pkg::CmdPage |
                         (fblcd_pkg::PixW'(page_q) & fblcd_pkg::PageMask);
          end
        end
        if (cnt_q[3]) begin
          cnt_d   = '0;
          state_d = fblcd_pkg::SeqData;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      fblcd_pkg::SeqData: begin
        out_valid_o = 1'b1;
        is_data_o   = 1'b1;
        for (int i = 0; i < 8; i++) begin
          lcd_byte_o[i] = rows_q[i][7];
          rows_d[i]     = {rows_q[i][6:0], 1'b0};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q[2:0] == 3'd7) begin
          last_o       = 1'b1;
          frame_done_o = final_tile;
          state_d      = fblcd_pkg::SeqIdle;
          if (tile_q == TileLast) begin
            tile_d = '0;
            if (page_q == PageLast) begin
              page_d   = '0;
              active_d = 1'b0;
            end else begin
              page_d = page_q + PAGE_W'(1);
            end
          end else begin
            tile_d = tile_q + TILE_W'(1);
          end
        end
      end
      default: begin
        state_d = fblcd_pkg::SeqIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fblcd_pkg::SeqIdle;
      cnt_q    <= '0;
      page_q   <= '0;
      tile_q   <= '0;
      dirty_q  <= 1'b0;
      active_q <= 1'b0;
      zero_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      page_q   <= page_d;
      tile_q   <= tile_d;
      dirty_q  <= dirty_d;
      active_q <= active_d;
      zero_q   <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q <= rows_d;
  end

  a_done_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_done_o |-> last_o && is_data_o && out_valid_o)
    else $error("frame_done without last data beat");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> state_q == fblcd_pkg::SeqIdle)
    else $error("sequencer busy after last beat");

  a_rd_captured : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req_o.rd_en |=> state_q == fblcd_pkg::SeqRead)
    else $error("read data not captured");

  a_write_dirty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req_o.wr_en |=> dirty_q && state_q == fblcd_pkg::SeqIdle)
    else $error("write did not mark picture dirty");

endmodule
